// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the key read port rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMCRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smcrd assertion failed");

// next-cycle implication, disabled during reset
`define SMCRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smcrd assertion failed");

`endif

// ===== rtl/core/smcrd_pkg.sv =====
// types, codes and key table constants for the key read port
package smcrd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int NUM_KEY_REGS = 8;

    localparam logic [7:0] CMD_KEY_READ    = 8'h10;
    localparam logic [7:0] ST_CMD_ACCEPTED = 8'h0c;
    localparam logic [7:0] ST_KEY_BYTE     = 8'h04;
    localparam logic [7:0] ST_DATA_READY   = 8'h05;
    localparam logic [7:0] ST_DONE         = 8'h00;

    localparam logic [7:0] LENGTH_WRITE_SLOT = 8'd4;
    localparam logic [7:0] MSSD_BYTE         = 8'h03;
    localparam int        REV_BYTES          = 6;
    localparam logic [6:0] OSK1_BASE         = 7'd32;

    // key names, first character in the low byte
    localparam logic [31:0] KEY_REV  = 32'h2056_4552;
    localparam logic [31:0] KEY_OSK0 = 32'h304b_534f;
    localparam logic [31:0] KEY_OSK1 = 32'h314b_534f;
    localparam logic [31:0] KEY_NATJ = 32'h4a54_414e;
    localparam logic [31:0] KEY_MSSP = 32'h5053_534d;
    localparam logic [31:0] KEY_MSSD = 32'h4453_534d;
    localparam logic [31:0] KEY_NTOK = 32'h4b4f_544e;

    typedef enum logic [2:0] {
        ENT_NONE,
        ENT_REV,
        ENT_OSK0,
        ENT_OSK1,
        ENT_ZERO,
        ENT_THREE
    } entry_t;

    typedef struct packed {
        logic       kind;
        logic       port_is_command;
        logic       byte_access;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       unused_access;
    } result_t;

    function automatic entry_t key_entry(input logic [31:0] name);
        entry_t e;
        e = ENT_NONE;
        if (name == KEY_REV)
        begin
            e = ENT_REV;
        end
        else if (name == KEY_OSK0)
        begin
            e = ENT_OSK0;
        end
        else if (name == KEY_OSK1)
        begin
            e = ENT_OSK1;
        end
        else if (name == KEY_NATJ || name == KEY_MSSP || name == KEY_NTOK)
        begin
            e = ENT_ZERO;
        end
        else if (name == KEY_MSSD)
        begin
            e = ENT_THREE;
        end
        return e;
    endfunction

    function automatic logic [7:0] rev_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h13;
            3'd2:    b = 8'h0f;
            3'd5:    b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/smc_key_read_port_device_top.sv =====
// key read port: a plain access returns a registered result; a buffered data read
// passes the buffer output register and S_READ, and the length write first runs
// S_COPY, writing the entry's bytes (6, MAX_ENTRY_BYTES, 1 or none if unknown) one per cycle.
// busy covers S_READ and S_COPY; one item per cycle otherwise, results cannot stall.
// rst_n clears all control state, the device key and the buffer valid bits at once,
// so the readout buffer reads as zero after reset without a clearing pass.
`include "assert_macros.svh"

module smc_key_read_port_device_top #(
    parameter int BUFFER_DEPTH    = 256,
    parameter int MAX_ENTRY_BYTES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  smcrd_pkg::item_t                    item,
    output logic                                done,
    output smcrd_pkg::result_t                  result,
    input  logic                                cfg_we,
    input  logic [smcrd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [smcrd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(MAX_ENTRY_BYTES + 1);
    localparam int WW = (CW > AW) ? CW : AW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COPY
    } state_t;

    state_t                 state_reg;
    logic                   done_reg;
    smcrd_pkg::result_t     result_reg;

    logic [7:0]             cmd_reg;
    logic [7:0]             status_reg;
    logic [7:0]             wcount_reg;
    logic [7:0]             len_reg;
    logic [7:0]             pos_reg;
    logic [31:0]            key_name_reg;
    smcrd_pkg::entry_t      entry_reg;
    logic [CW-1:0]          copy_len_reg;
    logic [CW-1:0]          copy_cnt_reg;

    logic [smcrd_pkg::NUM_KEY_REGS-1:0][smcrd_pkg::CFG_DATA_W-1:0] dev_key_reg;

    logic [7:0]             mem [BUFFER_DEPTH];
    logic [7:0]             mem_q_reg;
    logic [BUFFER_DEPTH-1:0] valid_reg;
    logic                   rd_hit_reg;

    logic                   accept;
    logic                   data_read;
    logic                   rd_in_range;
    logic [AW-1:0]          rd_addr;
    logic [7:0]             pos_next;
    smcrd_pkg::entry_t      new_entry;
    logic [CW-1:0]          new_len;
    logic [WW-1:0]          wr_idx;
    logic                   wr_in_range;
    logic [AW-1:0]          wr_addr;
    logic [6:0]             src_idx;
    logic [7:0]             key_byte;
    logic [7:0]             copy_byte;
    logic                   mem_we;
    logic                   copy_last;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign data_read = item.byte_access && !item.kind && !item.port_is_command
                    && (cmd_reg == smcrd_pkg::CMD_KEY_READ) && (pos_reg < len_reg);
    assign rd_in_range = ({1'b0, pos_reg} < 9'(BUFFER_DEPTH));
    assign rd_addr     = pos_reg[AW-1:0];
    assign pos_next    = pos_reg + 8'd1;

    assign new_entry = smcrd_pkg::key_entry(key_name_reg);

    always_comb
    begin
        case (new_entry)
            smcrd_pkg::ENT_REV:   new_len = CW'(smcrd_pkg::REV_BYTES);
            smcrd_pkg::ENT_OSK0:  new_len = CW'(MAX_ENTRY_BYTES);
            smcrd_pkg::ENT_OSK1:  new_len = CW'(MAX_ENTRY_BYTES);
            smcrd_pkg::ENT_ZERO:  new_len = CW'(1);
            smcrd_pkg::ENT_THREE: new_len = CW'(1);
            default:              new_len = '0;
        endcase
    end

    assign wr_idx      = WW'(copy_cnt_reg);
    assign wr_in_range = ({1'b0, wr_idx} < (WW + 1)'(BUFFER_DEPTH));
    assign wr_addr     = wr_idx[AW-1:0];
    assign src_idx     = 7'(copy_cnt_reg)
                       + ((entry_reg == smcrd_pkg::ENT_OSK1) ? smcrd_pkg::OSK1_BASE : 7'd0);
    assign key_byte    = src_idx[6] ? 8'h00
                       : dev_key_reg[src_idx[5:3]][{src_idx[2:0], 3'b000} +: 8];
    assign mem_we      = (state_reg == S_COPY) && wr_in_range;
    assign copy_last   = (copy_cnt_reg == copy_len_reg - CW'(1));

    always_comb
    begin
        case (entry_reg)
            smcrd_pkg::ENT_REV:   copy_byte = smcrd_pkg::rev_byte(copy_cnt_reg[2:0]);
            smcrd_pkg::ENT_OSK0:  copy_byte = key_byte;
            smcrd_pkg::ENT_OSK1:  copy_byte = key_byte;
            smcrd_pkg::ENT_THREE: copy_byte = smcrd_pkg::MSSD_BYTE;
            default:              copy_byte = 8'h00;
        endcase
    end

    // device key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            dev_key_reg[cfg_index] <= cfg_data;
        end
    end

    // readout buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= copy_byte;
        end
        if (accept && data_read)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (accept && data_read)
            begin
                rd_hit_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    // control and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            result_reg   <= '0;
            cmd_reg      <= '0;
            status_reg   <= smcrd_pkg::ST_DONE;
            wcount_reg   <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            key_name_reg <= '0;
            entry_reg    <= smcrd_pkg::ENT_NONE;
            copy_len_reg <= '0;
            copy_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        if (!item.byte_access)
                        begin
                            result_reg.unused_access <= !item.kind;
                        end
                        else if (!item.kind)
                        begin
                            if (item.port_is_command)
                            begin
                                result_reg.rd_byte <= status_reg;
                            end
                            else if (data_read)
                            begin
                                pos_reg    <= pos_next;
                                status_reg <= (pos_next == len_reg) ? smcrd_pkg::ST_DONE
                                                                    : smcrd_pkg::ST_DATA_READY;
                                done_reg   <= 1'b0;
                                state_reg  <= S_READ;
                            end
                        end
                        else if (item.port_is_command)
                        begin
                            if (item.write_data == smcrd_pkg::CMD_KEY_READ)
                            begin
                                status_reg <= smcrd_pkg::ST_CMD_ACCEPTED;
                            end
                            cmd_reg    <= item.write_data;
                            wcount_reg <= '0;
                            pos_reg    <= '0;
                        end
                        else if (cmd_reg == smcrd_pkg::CMD_KEY_READ)
                        begin
                            if (wcount_reg < smcrd_pkg::LENGTH_WRITE_SLOT)
                            begin
                                key_name_reg[{wcount_reg[1:0], 3'b000} +: 8] <= item.write_data;
                                status_reg <= smcrd_pkg::ST_KEY_BYTE;
                            end
                            else if (wcount_reg == smcrd_pkg::LENGTH_WRITE_SLOT)
                            begin
                                len_reg      <= item.write_data;
                                status_reg   <= smcrd_pkg::ST_DATA_READY;
                                pos_reg      <= '0;
                                entry_reg    <= new_entry;
                                copy_len_reg <= new_len;
                                copy_cnt_reg <= '0;
                                if (new_len != '0)
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_COPY;
                                end
                            end
                            wcount_reg <= wcount_reg + 8'd1;
                        end
                    end
                end
                S_READ:
                begin
                    done_reg                 <= 1'b1;
                    result_reg.rd_byte       <= rd_hit_reg ? mem_q_reg : 8'h00;
                    result_reg.unused_access <= 1'b0;
                    state_reg                <= S_IDLE;
                end
                S_COPY:
                begin
                    copy_cnt_reg <= copy_cnt_reg + CW'(1);
                    if (copy_last)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SMCRD_ASSERT_IMP(a_pos_within_len, clk, rst_n, 1'b1, pos_reg <= len_reg)
    `SMCRD_ASSERT_IMP(a_status_code, clk, rst_n, 1'b1,
        status_reg == smcrd_pkg::ST_DONE || status_reg == smcrd_pkg::ST_KEY_BYTE ||
        status_reg == smcrd_pkg::ST_DATA_READY || status_reg == smcrd_pkg::ST_CMD_ACCEPTED)
    `SMCRD_ASSERT_IMP(a_copy_bound, clk, rst_n, state_reg == S_COPY,
        copy_cnt_reg < copy_len_reg)
    `SMCRD_ASSERT_NXT(a_read_delivers, clk, rst_n, state_reg == S_READ,
        done_reg && state_reg == S_IDLE)

endmodule

// ===== tb/smc_key_read_port_device_checker.sv =====
`timescale 1ns / 100ps
// checker for the key read port: predicts each result and compares it against the block

module smc_key_read_port_device_checker
    import smcrd_pkg::*;
#(
    parameter int BUFFER_DEPTH    = 256,
    parameter int MAX_ENTRY_BYTES = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  item_t                    item,
    input  logic                     done,
    input  result_t                  result,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       mismatch_count,
    output int                       outstanding
);

    logic [CFG_DATA_W-1:0] device_key [NUM_KEY_REGS];
    logic [7:0]  active_command;
    logic [7:0]  status_reg;
    logic [31:0] key_name;
    logic [7:0]  key_write_count;
    logic [7:0]  readout_len;
    logic [7:0]  readout_pos;
    logic [7:0]  readout_buf [BUFFER_DEPTH];

    result_t port_response_q [$];

    assign outstanding = port_response_q.size();

    function automatic logic [7:0] device_key_byte(input int idx);
        logic [7:0] b;
        b = '0;
        if (idx < NUM_KEY_REGS * 8)
        begin
            b = device_key[idx / 8][8 * (idx % 8) +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] rev_entry_byte(input int idx);
        logic [7:0] b;
        case (idx)
            0:       b = 8'h01;
            1:       b = 8'h13;
            2:       b = 8'h0f;
            5:       b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    task automatic store_readout(input int idx, input logic [7:0] value);
        if (idx < BUFFER_DEPTH)
        begin
            readout_buf[idx] = value;
        end
    endtask

    task automatic fill_readout();
        int i;
        case (key_name)
            KEY_REV:
            begin
                for (i = 0; i < REV_BYTES; i++)
                begin
                    store_readout(i, rev_entry_byte(i));
                end
            end
            KEY_OSK0:
            begin
                for (i = 0; i < MAX_ENTRY_BYTES; i++)
                begin
                    store_readout(i, device_key_byte(i));
                end
            end
            KEY_OSK1:
            begin
                for (i = 0; i < MAX_ENTRY_BYTES; i++)
                begin
                    store_readout(i, device_key_byte(int'(OSK1_BASE) + i));
                end
            end
            KEY_NATJ, KEY_MSSP, KEY_NTOK:
            begin
                store_readout(0, 8'h00);
            end
            KEY_MSSD:
            begin
                store_readout(0, MSSD_BYTE);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_port_access(input item_t acc, output result_t res);
        res = '0;
        if (!acc.byte_access)
        begin
            res.unused_access = !acc.kind;
        end
        else if (!acc.kind)
        begin
            if (acc.port_is_command)
            begin
                res.rd_byte = status_reg;
            end
            else if (active_command == CMD_KEY_READ && readout_pos < readout_len)
            begin
                if (int'(readout_pos) < BUFFER_DEPTH)
                begin
                    res.rd_byte = readout_buf[readout_pos];
                end
                readout_pos = readout_pos + 8'd1;
                status_reg = (readout_pos == readout_len) ? ST_DONE : ST_DATA_READY;
            end
        end
        else if (acc.port_is_command)
        begin
            if (acc.write_data == CMD_KEY_READ)
            begin
                status_reg = ST_CMD_ACCEPTED;
            end
            active_command = acc.write_data;
            key_write_count = '0;
            readout_pos = '0;
        end
        else if (active_command == CMD_KEY_READ)
        begin
            if (key_write_count < LENGTH_WRITE_SLOT)
            begin
                key_name[8 * key_write_count +: 8] = acc.write_data;
                status_reg = ST_KEY_BYTE;
            end
            else if (key_write_count == LENGTH_WRITE_SLOT)
            begin
                readout_len = acc.write_data;
                status_reg = ST_DATA_READY;
                readout_pos = '0;
                fill_readout();
            end
            key_write_count = key_write_count + 8'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t due;
        result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEY_REGS; i++)
            begin
                device_key[i] = '0;
            end
            for (int i = 0; i < BUFFER_DEPTH; i++)
            begin
                readout_buf[i] = '0;
            end
            active_command = '0;
            status_reg = '0;
            key_name = '0;
            key_write_count = '0;
            readout_len = '0;
            readout_pos = '0;
            mismatch_count = 0;
            port_response_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (port_response_q.size() == 0)
                begin
                    $error("result with no item waiting: rd_byte %0h unused_access %0b",
                           result.rd_byte, result.unused_access);
                    mismatch_count++;
                end
                else
                begin
                    due = port_response_q.pop_front();
                    if (result.rd_byte !== due.rd_byte)
                    begin
                        $error("rd_byte: expected %0h, actual %0h",
                               due.rd_byte, result.rd_byte);
                        mismatch_count++;
                    end
                    if (result.unused_access !== due.unused_access)
                    begin
                        $error("unused_access: expected %0b, actual %0b",
                               due.unused_access, result.unused_access);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we && cfg_index < NUM_KEY_REGS)
            begin
                device_key[cfg_index] = cfg_data;
            end
            if (start && !busy)
            begin
                predict_port_access(item, fresh);
                port_response_q.push_back(fresh);
            end
        end
    end

endmodule

// ===== tb/tb_smc_key_read_port_device_top.sv =====
`timescale 1ns / 100ps
// testbench top for the key read port: clock, reset, stimulus and verdict

module tb_smc_key_read_port_device_top;
    import smcrd_pkg::*;

    localparam int BUFFER_DEPTH    = 256;
    localparam int MAX_ENTRY_BYTES = 32;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 2 * (MAX_ENTRY_BYTES + 2);
    localparam int ITEMS_PER_PHASE = 120;
    localparam int MAX_GAP         = 12;

    localparam logic ACC_READ   = 1'b0;
    localparam logic ACC_WRITE  = 1'b1;
    localparam logic PORT_DATA  = 1'b0;
    localparam logic PORT_CMD   = 1'b1;
    localparam logic WIDTH_WIDE = 1'b0;
    localparam logic WIDTH_BYTE = 1'b1;

    typedef enum int {
        KEY_FILL_RANDOM,
        KEY_FILL_ONES,
        KEY_FILL_ZEROS
    } key_fill_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    item_t                   item = '0;
    logic                    done;
    result_t                 result;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int fail_count;
    int responses_due;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int items_sent = 0;

    always #10 clk = ~clk;

    smc_key_read_port_device_top #(
        .BUFFER_DEPTH    (BUFFER_DEPTH),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smc_key_read_port_device_checker #(
        .BUFFER_DEPTH    (BUFFER_DEPTH),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (fail_count),
        .outstanding    (responses_due)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("smc_key_read_port_device_top verification failed");
            $finish;
        end
    end

    task automatic send_access(input logic kind_v, input logic port_v, input logic width_v,
                               input logic [7:0] data_v);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= '{kind_v, port_v, width_v, data_v};
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic command_write(input logic [7:0] value);
        send_access(ACC_WRITE, PORT_CMD, WIDTH_BYTE, value);
    endtask

    task automatic status_read();
        send_access(ACC_READ, PORT_CMD, WIDTH_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic data_write(input logic [7:0] value);
        send_access(ACC_WRITE, PORT_DATA, WIDTH_BYTE, value);
    endtask

    task automatic data_read();
        send_access(ACC_READ, PORT_DATA, WIDTH_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic noise_access();
        send_access(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    8'($urandom_range(255)));
    endtask

    task automatic send_key_name(input logic [31:0] name);
        for (int b = 0; b < 4; b++)
        begin
            data_write(name[8 * b +: 8]);
        end
    endtask

    // no item in flight on return
    task automatic settle_idle();
        start <= 1'b0;
        while (responses_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_device_key(input key_fill_t fill);
        for (int i = 0; i < NUM_KEY_REGS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            case (fill)
                KEY_FILL_ONES:  cfg_data <= '1;
                KEY_FILL_ZEROS: cfg_data <= '0;
                default:        cfg_data <= {$urandom, $urandom};
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] table_key(input int sel);
        logic [31:0] k;
        case (sel)
            0:       k = KEY_REV;
            1:       k = KEY_OSK0;
            2:       k = KEY_OSK1;
            3:       k = KEY_NATJ;
            4:       k = KEY_MSSP;
            5:       k = KEY_MSSD;
            default: k = KEY_NTOK;
        endcase
        return k;
    endfunction

    task automatic key_read_sequence();
        logic [31:0] name;
        int pick;
        int len;
        int reads;
        pick = $urandom_range(9);
        if (pick < 7)
        begin
            name = table_key(pick);
        end
        else if (pick == 7)
        begin
            name = $urandom;
        end
        else
        begin
            // near miss of a table name
            name = table_key($urandom_range(6)) ^ (32'd1 << $urandom_range(31));
        end
        command_write(CMD_KEY_READ);
        if ($urandom_range(7) == 0)
        begin
            status_read();
        end
        for (int b = 0; b < 4; b++)
        begin
            if ($urandom_range(19) == 0)
            begin
                noise_access();
            end
            data_write(name[8 * b +: 8]);
        end
        len = ($urandom_range(11) == 0) ? $urandom_range(255) : $urandom_range(40);
        data_write(8'(len));
        reads = ((len > 40) ? 40 : len) + $urandom_range(3);
        for (int i = 0; i < reads; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                status_read();
            end
            if ($urandom_range(11) == 0)
            begin
                data_write(8'($urandom_range(255)));
            end
            data_read();
        end
        status_read();
    endtask

    // write counter runs through all 256 values and takes a fresh key name
    task automatic wrap_sequence();
        command_write(CMD_KEY_READ);
        for (int i = 0; i < 256; i++)
        begin
            data_write(8'($urandom_range(255)));
        end
        send_key_name(KEY_REV);
        data_write(8'(REV_BYTES));
        for (int i = 0; i <= REV_BYTES; i++)
        begin
            data_read();
        end
        status_read();
    endtask

    initial
    begin
        int phase_start;
        bit wrap_done;
        wrap_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_device_key(KEY_FILL_RANDOM);

        status_read();
        data_read();
        send_access(ACC_READ, PORT_CMD, WIDTH_WIDE, 8'hff);
        send_access(ACC_WRITE, PORT_DATA, WIDTH_WIDE, 8'hff);
        data_write(8'hff);
        command_write(8'hff);
        status_read();
        command_write(CMD_KEY_READ);
        status_read();
        send_key_name(KEY_REV);
        data_write(8'(REV_BYTES + 1));
        status_read();
        for (int i = 0; i < REV_BYTES + 2; i++)
        begin
            data_read();
        end
        status_read();
        data_write(8'h00);

        for (int phase = 0; phase < 3; phase++)
        begin
            settle_idle();
            case (phase)
                0:
                begin
                    load_device_key(KEY_FILL_ONES);
                    sender_idle_pct = 29;
                end
                1:
                begin
                    load_device_key(KEY_FILL_ZEROS);
                    sender_idle_pct = 71;
                end
                default:
                begin
                    load_device_key(KEY_FILL_RANDOM);
                    sender_idle_pct = 0;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if (phase == 2 && !wrap_done)
                begin
                    wrap_sequence();
                    wrap_done = 1'b1;
                end
                else if ($urandom_range(9) < 8)
                begin
                    key_read_sequence();
                end
                else
                begin
                    noise_access();
                end
            end
        end

        settle_idle();
        @(negedge clk);
        if (fail_count == 0 && responses_due == 0)
        begin
            $display("smc_key_read_port_device_top verification clean");
        end
        else
        begin
            $display("smc_key_read_port_device_top verification failed");
        end
        $finish;
    end

endmodule
